// ===== rtl/necc_pkg.sv =====
`timescale 1ns / 1ps
// necc_pkg: shared types, register codes, reset values and verdict codes
// for the erased-chunk bit-flip checker; no dependencies

package necc_pkg;

   localparam int MAX_DATA_BLOCKS_DEF = 64;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QAW         = $clog2(QUEUE_DEPTH);

   // csr port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_META_BYTES       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_META_STRENGTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_META_FIELD_BITS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BLOCK_BYTES = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_STRENGTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_FIELD_BITS  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_BLOCKS      = 3'd6;

   localparam logic [7:0]  RST_META_BYTES       = 8'd16;
   localparam logic [5:0]  RST_META_STRENGTH    = 6'd8;
   localparam logic [3:0]  RST_META_FIELD_BITS  = 4'd13;
   localparam logic [10:0] RST_DATA_BLOCK_BYTES = 11'd512;
   localparam logic [5:0]  RST_DATA_STRENGTH    = 6'd8;
   localparam logic [3:0]  RST_DATA_FIELD_BITS  = 4'd13;
   localparam logic [6:0]  RST_DATA_BLOCKS      = 7'd8;

   localparam logic [10:0] MAX_PAYLOAD_BYTES = 11'd1024;

   localparam logic [1:0] VERDICT_CLEAN = 2'd0;
   localparam logic [1:0] VERDICT_FILL  = 2'd1;
   localparam logic [1:0] VERDICT_FAULT = 2'd2;

   typedef struct packed {
      logic [7:0]  meta_bytes;
      logic [5:0]  meta_strength;
      logic [3:0]  meta_field_bits;
      logic [10:0] data_block_bytes;
      logic [5:0]  data_strength;
      logic [3:0]  data_field_bits;
      logic [6:0]  data_blocks;
   } cfg_type;

   // one classified byte, as handed from front to back
   typedef struct packed {
      logic       start;    // first byte of a page: count restarts
      logic       at_end;   // a chunk ends inside this byte
      logic       last;     // that chunk is the final one of the page
      logic [6:0] chunk;    // chunk the low part of the byte belongs to
      logic [3:0] z_lo;     // zeros below the cut (whole byte if no end)
      logic [3:0] z_hi;     // zeros above the cut, start of next chunk
   } cmd_type;

endpackage

// ===== rtl/necc_regs.sv =====
`timescale 1ns / 1ps
// necc_regs: configuration registers behind the csr write channel
// depends on necc_pkg

module necc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [necc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [necc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output necc_pkg::cfg_type                 cfg
);

   necc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.meta_bytes       <= necc_pkg::RST_META_BYTES;
         cfg_ff.meta_strength    <= necc_pkg::RST_META_STRENGTH;
         cfg_ff.meta_field_bits  <= necc_pkg::RST_META_FIELD_BITS;
         cfg_ff.data_block_bytes <= necc_pkg::RST_DATA_BLOCK_BYTES;
         cfg_ff.data_strength    <= necc_pkg::RST_DATA_STRENGTH;
         cfg_ff.data_field_bits  <= necc_pkg::RST_DATA_FIELD_BITS;
         cfg_ff.data_blocks      <= necc_pkg::RST_DATA_BLOCKS;
      end else if (csr_valid) begin
         unique case (csr_index)
            necc_pkg::CSR_META_BYTES:       cfg_ff.meta_bytes       <= csr_wdata[7:0];
            necc_pkg::CSR_META_STRENGTH:    cfg_ff.meta_strength    <= csr_wdata[5:0];
            necc_pkg::CSR_META_FIELD_BITS:  cfg_ff.meta_field_bits  <= csr_wdata[3:0];
            necc_pkg::CSR_DATA_BLOCK_BYTES: cfg_ff.data_block_bytes <= csr_wdata[10:0];
            necc_pkg::CSR_DATA_STRENGTH:    cfg_ff.data_strength    <= csr_wdata[5:0];
            necc_pkg::CSR_DATA_FIELD_BITS:  cfg_ff.data_field_bits  <= csr_wdata[3:0];
            necc_pkg::CSR_DATA_BLOCKS:      cfg_ff.data_blocks      <= csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== rtl/necc_front.sv =====
`timescale 1ns / 1ps
// necc_front: tracks the chunk position of each accepted byte and classifies it
// into a queue command; depends on necc_pkg

module necc_front #(
   parameter int MAX_DATA_BLOCKS = necc_pkg::MAX_DATA_BLOCKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  necc_pkg::cfg_type   cfg,
   input  logic                fire,
   input  logic [7:0]          raw_byte,
   input  logic                page_start,
   output logic                push,
   output necc_pkg::cmd_type   cmd
);

   logic [13:0] bits_left_ff, bits_left_in;
   logic [6:0]  chunk_ff, chunk_in;
   logic        page_done_ff, page_done_in;
   logic [13:0] dlen_ff;

   logic [7:0]  mb;
   logic [10:0] db;
   logic [9:0]  meta_par, data_par;
   logic [13:0] meta_len, data_len;
   logic [13:0] bl_cur, dlen_cur;
   logic [6:0]  chunk_cur, limit;
   logic        active, at_end, last;
   logic [3:0]  cut;
   logic [7:0]  lo_mask, zeros;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + {3'b0, v[i]};
      end
      return n;
   endfunction

   always_comb begin
      mb = (cfg.meta_bytes == 8'd0) ? 8'd1 : cfg.meta_bytes;
      if (cfg.data_block_bytes == 11'd0) begin
         db = 11'd1;
      end else if (cfg.data_block_bytes > necc_pkg::MAX_PAYLOAD_BYTES) begin
         db = necc_pkg::MAX_PAYLOAD_BYTES;
      end else begin
         db = cfg.data_block_bytes;
      end
      meta_par = cfg.meta_strength * cfg.meta_field_bits;
      data_par = cfg.data_strength * cfg.data_field_bits;
      meta_len = {3'b0, mb, 3'b0} + {4'b0, meta_par};
      data_len = {db, 3'b0} + {4'b0, data_par};

      bl_cur    = page_start ? meta_len : bits_left_ff;
      dlen_cur  = page_start ? data_len : dlen_ff;
      chunk_cur = page_start ? 7'd0 : chunk_ff;
      active    = page_start || !page_done_ff;

      // a chunk is never shorter than a byte, so at most one cut per byte
      at_end = (bl_cur <= 14'd8);
      cut    = at_end ? bl_cur[3:0] : 4'd8;
      for (int i = 0; i < 8; i++) begin
         lo_mask[i] = (4'(i) < cut);
      end
      zeros = ~raw_byte;

      limit = (cfg.data_blocks > 7'(MAX_DATA_BLOCKS)) ? 7'(MAX_DATA_BLOCKS)
                                                      : cfg.data_blocks;
      last  = (chunk_cur >= limit);

      bits_left_in = bits_left_ff;
      chunk_in     = chunk_ff;
      page_done_in = page_done_ff;
      if (fire && active) begin
         if (at_end) begin
            if (last) begin
               page_done_in = 1'b1;
            end else begin
               chunk_in     = chunk_cur + 7'd1;
               bits_left_in = dlen_cur - (14'd8 - {10'b0, cut});
               page_done_in = 1'b0;
            end
         end else begin
            chunk_in     = chunk_cur;
            bits_left_in = bl_cur - 14'd8;
            page_done_in = 1'b0;
         end
      end

      push       = fire && active;
      cmd.start  = page_start;
      cmd.at_end = at_end;
      cmd.last   = last;
      cmd.chunk  = chunk_cur;
      cmd.z_lo   = popcount8(zeros & lo_mask);
      cmd.z_hi   = popcount8(zeros & ~lo_mask);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_left_ff <= 14'd0;
         chunk_ff     <= 7'd0;
         page_done_ff <= 1'b1;
      end else begin
         bits_left_ff <= bits_left_in;
         chunk_ff     <= chunk_in;
         page_done_ff <= page_done_in;
      end
   end

   // data chunk length is fixed for the whole page
   always_ff @(posedge clock) begin
      if (fire && page_start) begin
         dlen_ff <= data_len;
      end
   end

endmodule

// ===== rtl/necc_queue.sv =====
`timescale 1ns / 1ps
// necc_queue: short command queue that decouples front and back
// depends on necc_pkg

module necc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  necc_pkg::cmd_type   push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                q_valid,
   output necc_pkg::cmd_type   q_cmd
);

   localparam int DEPTH = necc_pkg::QUEUE_DEPTH;
   localparam int AW    = necc_pkg::QAW;

   necc_pkg::cmd_type    mem_ff [DEPTH];
   logic [AW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [AW:0]          count_ff;

   function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_inc(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + (AW+1)'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - (AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("pop from empty queue");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + (AW+1)'(1))
      else $error("queue count lost a push");

endmodule

// ===== rtl/necc_back.sv =====
`timescale 1ns / 1ps
// necc_back: accumulates zero counts per chunk and issues verdicts through
// a registered result stage; depends on necc_pkg

module necc_back (
   input  logic                clock,
   input  logic                reset,
   input  necc_pkg::cfg_type   cfg,
   input  logic                q_valid,
   input  necc_pkg::cmd_type   q_cmd,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [6:0]          rsp_chunk_index,
   output logic [13:0]         rsp_zero_bits,
   output logic [1:0]          rsp_verdict,
   output logic                rsp_last_chunk
);

   logic [13:0] count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  chunk_ff;
   logic [13:0] zero_bits_ff;
   logic [1:0]  verdict_ff, verdict_in;
   logic        last_ff;

   logic [13:0] base, sum;
   logic [5:0]  strength;
   logic        out_free;

   always_comb begin
      base     = q_cmd.start ? 14'd0 : count_ff;
      sum      = base + {10'b0, q_cmd.z_lo};
      strength = (q_cmd.chunk == 7'd0) ? cfg.meta_strength : cfg.data_strength;
      if (sum == 14'd0) begin
         verdict_in = necc_pkg::VERDICT_CLEAN;
      end else if (sum > {8'b0, strength}) begin
         verdict_in = necc_pkg::VERDICT_FAULT;
      end else begin
         verdict_in = necc_pkg::VERDICT_FILL;
      end

      out_free = !rsp_valid_ff || !rsp_stall;
      // bytes without a boundary never wait on the result stage
      pop = q_valid && (!q_cmd.at_end || out_free);

      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop) begin
         if (q_cmd.at_end) begin
            count_in     = q_cmd.last ? 14'd0 : {10'b0, q_cmd.z_hi};
            rsp_valid_in = 1'b1;
         end else begin
            count_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 14'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && q_cmd.at_end) begin
         chunk_ff     <= q_cmd.chunk;
         zero_bits_ff <= sum;
         verdict_ff   <= verdict_in;
         last_ff      <= q_cmd.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chunk_index = chunk_ff;
   assign rsp_zero_bits   = zero_bits_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_last_chunk  = last_ff;

   a_clean_iff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_verdict == necc_pkg::VERDICT_CLEAN) == (rsp_zero_bits == 14'd0)))
      else $error("clean verdict disagrees with zero count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !(pop && q_cmd.at_end))
      else $error("result overwritten while stalled");

   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == necc_pkg::VERDICT_CLEAN ||
                     rsp_verdict == necc_pkg::VERDICT_FILL ||
                     rsp_verdict == necc_pkg::VERDICT_FAULT))
      else $error("bad verdict code");

endmodule

// ===== rtl/nand_erased_chunk_bitflip_check_core.sv =====
`timescale 1ns / 1ps
// nand_erased_chunk_bitflip_check_core: top level of the erased-chunk checker
// depends on necc_pkg, necc_regs, necc_front, necc_queue, necc_back
//
// usage
//   req_*  : one raw page byte per item, lsb first in the bit stream;
//            req_page_start marks the first byte of a page
//   rsp_*  : one item per finished chunk: index, zero bit count, verdict
//            (clean, fill with 0xff, fault) and a last-chunk flag
//   csr_*  : register writes, always ready; write only while no item is in
//            flight, chunk lengths are latched at each page start
// timing
//   one byte per cycle sustained while rsp_stall is low; a byte that ends
//   a chunk is written into the queue when accepted, then the back pops it
//   and loads its result into the result register that drives rsp_*
//   bytes outside a page, or after the final chunk, are dropped silently
// reset
//   registers return to their defaults and the block waits for a page start
// stall
//   while rsp_stall holds, the result register keeps its item; the back keeps
//   draining bytes that end no chunk, the four-entry queue fills, and
//   req_stall rises once the queue is full

module nand_erased_chunk_bitflip_check_core #(
   parameter int MAX_DATA_BLOCKS = necc_pkg::MAX_DATA_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_raw_byte,
   input  logic                             req_page_start,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [6:0]                       rsp_chunk_index,
   output logic [13:0]                      rsp_zero_bits,
   output logic [1:0]                       rsp_verdict,
   output logic                             rsp_last_chunk,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [necc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [necc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   necc_pkg::cfg_type cfg;
   necc_pkg::cmd_type push_cmd, q_cmd;
   logic              req_fire, push, full, pop, q_valid;

   // input side only waits on queue space
   assign req_stall = full;
   assign req_fire  = req_valid && !req_stall;

   necc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // position tracking and per-byte classification
   necc_front #(
      .MAX_DATA_BLOCKS (MAX_DATA_BLOCKS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .fire       (req_fire),
      .raw_byte   (req_raw_byte),
      .page_start (req_page_start),
      .push       (push),
      .cmd        (push_cmd)
   );

   necc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   // counting, verdict and result register
   necc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chunk_index (rsp_chunk_index),
      .rsp_zero_bits   (rsp_zero_bits),
      .rsp_verdict     (rsp_verdict),
      .rsp_last_chunk  (rsp_last_chunk)
   );

endmodule
